// ===== rtl/core/mipsdec_pkg.sv =====
// Package for the MIPS subset instruction decoder.
// Holds the transfer payload types, format and class codes, and the opcode table.
// Depends on nothing; every module of the decoder imports it.
package mipsdec_pkg;

  localparam int unsigned NUM_ENTRIES = 27;

  // Instruction formats.
  localparam logic [1:0] FMT_R = 2'd0;
  localparam logic [1:0] FMT_I = 2'd1;
  localparam logic [1:0] FMT_J = 2'd2;

  // Operand classes.
  localparam logic [3:0] CL_R_ARITH  = 4'd0;
  localparam logic [3:0] CL_R_SHAMT  = 4'd1;
  localparam logic [3:0] CL_R_JUMP   = 4'd2;
  localparam logic [3:0] CL_R_LOGIC  = 4'd3;
  localparam logic [3:0] CL_I_ARITH  = 4'd4;
  localparam logic [3:0] CL_I_BRANCH = 4'd5;
  localparam logic [3:0] CL_I_LOAD   = 4'd6;
  localparam logic [3:0] CL_I_LOGIC  = 4'd7;
  localparam logic [3:0] CL_I_MEM    = 4'd8;
  localparam logic [3:0] CL_J_JUMP   = 4'd9;

  // Table positions, in table order.
  localparam logic [4:0] IDX_ADD   = 5'd0;
  localparam logic [4:0] IDX_ADDU  = 5'd1;
  localparam logic [4:0] IDX_SUB   = 5'd2;
  localparam logic [4:0] IDX_SUBU  = 5'd3;
  localparam logic [4:0] IDX_ADDI  = 5'd4;
  localparam logic [4:0] IDX_ADDIU = 5'd5;
  localparam logic [4:0] IDX_SLL   = 5'd6;
  localparam logic [4:0] IDX_SRL   = 5'd7;
  localparam logic [4:0] IDX_BEQ   = 5'd8;
  localparam logic [4:0] IDX_BNE   = 5'd9;
  localparam logic [4:0] IDX_J     = 5'd10;
  localparam logic [4:0] IDX_JR    = 5'd11;
  localparam logic [4:0] IDX_LUI   = 5'd12;
  localparam logic [4:0] IDX_AND   = 5'd13;
  localparam logic [4:0] IDX_OR    = 5'd14;
  localparam logic [4:0] IDX_XOR   = 5'd15;
  localparam logic [4:0] IDX_ANDI  = 5'd16;
  localparam logic [4:0] IDX_ORI   = 5'd17;
  localparam logic [4:0] IDX_XORI  = 5'd18;
  localparam logic [4:0] IDX_LB    = 5'd19;
  localparam logic [4:0] IDX_LH    = 5'd20;
  localparam logic [4:0] IDX_LW    = 5'd21;
  localparam logic [4:0] IDX_LBU   = 5'd22;
  localparam logic [4:0] IDX_LHU   = 5'd23;
  localparam logic [4:0] IDX_SB    = 5'd24;
  localparam logic [4:0] IDX_SH    = 5'd25;
  localparam logic [4:0] IDX_SW    = 5'd26;

  // Opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes of opcode-zero instructions.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;

  // Access property bytes.
  localparam logic [7:0] PROP_NONE   = 8'h00;
  localparam logic [7:0] PROP_FLOW   = 8'h01;
  localparam logic [7:0] PROP_LB     = 8'h12;
  localparam logic [7:0] PROP_LH     = 8'h16;
  localparam logic [7:0] PROP_LW     = 8'h1a;
  localparam logic [7:0] PROP_LBU    = 8'h10;
  localparam logic [7:0] PROP_LHU    = 8'h14;
  localparam logic [7:0] PROP_SB     = 8'h81;
  localparam logic [7:0] PROP_SH     = 8'ha1;
  localparam logic [7:0] PROP_SW     = 8'hc1;

  localparam logic [31:0] LUI_SHIFT = 32'd16;
  localparam logic [31:0] PC_STEP   = 32'd4;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] pc;
  } instr_item_t;

  typedef struct packed {
    logic        known;
    logic [4:0]  entry_index;
    logic [1:0]  format_kind;
    logic [3:0]  operand_class;
    logic [4:0]  rs_num;
    logic [4:0]  rt_num;
    logic [4:0]  rd_num;
    logic [25:0] first_operand;
    logic [31:0] second_operand;
    logic [15:0] branch_offset;
    logic [7:0]  access_props;
    logic [31:0] next_pc;
  } dec_item_t;

  // One table row as seen by the operand stage.
  typedef struct packed {
    logic       hit;
    logic [4:0] index;
    logic [1:0] fmt;
    logic [3:0] cls;
    logic [7:0] props;
  } match_t;

  function automatic match_t make_row(logic [4:0] idx, logic [1:0] fmt, logic [3:0] cls,
                                      logic [7:0] props);
    match_t r;
    r.hit   = 1'b1;
    r.index = idx;
    r.fmt   = fmt;
    r.cls   = cls;
    r.props = props;
    return r;
  endfunction

  // Opcode-zero words match on funct; all others on the opcode alone.
  function automatic match_t lookup_row(logic [5:0] opcode, logic [5:0] funct);
    match_t r;
    r = '0;
    if (opcode == OP_SPECIAL) begin
      case (funct)
        FN_ADD:  r = make_row(IDX_ADD,  FMT_R, CL_R_ARITH, PROP_NONE);
        FN_ADDU: r = make_row(IDX_ADDU, FMT_R, CL_R_ARITH, PROP_NONE);
        FN_SUB:  r = make_row(IDX_SUB,  FMT_R, CL_R_ARITH, PROP_NONE);
        FN_SUBU: r = make_row(IDX_SUBU, FMT_R, CL_R_ARITH, PROP_NONE);
        FN_SLL:  r = make_row(IDX_SLL,  FMT_R, CL_R_SHAMT, PROP_NONE);
        FN_SRL:  r = make_row(IDX_SRL,  FMT_R, CL_R_SHAMT, PROP_NONE);
        FN_JR:   r = make_row(IDX_JR,   FMT_R, CL_R_JUMP,  PROP_FLOW);
        FN_AND:  r = make_row(IDX_AND,  FMT_R, CL_R_LOGIC, PROP_NONE);
        FN_OR:   r = make_row(IDX_OR,   FMT_R, CL_R_LOGIC, PROP_NONE);
        FN_XOR:  r = make_row(IDX_XOR,  FMT_R, CL_R_LOGIC, PROP_NONE);
        default: r = '0;
      endcase
    end else begin
      case (opcode)
        OP_ADDI:  r = make_row(IDX_ADDI,  FMT_I, CL_I_ARITH,  PROP_NONE);
        OP_ADDIU: r = make_row(IDX_ADDIU, FMT_I, CL_I_ARITH,  PROP_NONE);
        OP_BEQ:   r = make_row(IDX_BEQ,   FMT_I, CL_I_BRANCH, PROP_FLOW);
        OP_BNE:   r = make_row(IDX_BNE,   FMT_I, CL_I_BRANCH, PROP_FLOW);
        OP_J:     r = make_row(IDX_J,     FMT_J, CL_J_JUMP,   PROP_FLOW);
        OP_LUI:   r = make_row(IDX_LUI,   FMT_I, CL_I_LOAD,   PROP_NONE);
        OP_ANDI:  r = make_row(IDX_ANDI,  FMT_I, CL_I_LOGIC,  PROP_NONE);
        OP_ORI:   r = make_row(IDX_ORI,   FMT_I, CL_I_LOGIC,  PROP_NONE);
        OP_XORI:  r = make_row(IDX_XORI,  FMT_I, CL_I_LOGIC,  PROP_NONE);
        OP_LB:    r = make_row(IDX_LB,    FMT_I, CL_I_MEM,    PROP_LB);
        OP_LH:    r = make_row(IDX_LH,    FMT_I, CL_I_MEM,    PROP_LH);
        OP_LW:    r = make_row(IDX_LW,    FMT_I, CL_I_MEM,    PROP_LW);
        OP_LBU:   r = make_row(IDX_LBU,   FMT_I, CL_I_MEM,    PROP_LBU);
        OP_LHU:   r = make_row(IDX_LHU,   FMT_I, CL_I_MEM,    PROP_LHU);
        OP_SB:    r = make_row(IDX_SB,    FMT_I, CL_I_MEM,    PROP_SB);
        OP_SH:    r = make_row(IDX_SH,    FMT_I, CL_I_MEM,    PROP_SH);
        OP_SW:    r = make_row(IDX_SW,    FMT_I, CL_I_MEM,    PROP_SW);
        default:  r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mipsdec_match.sv =====
// Opcode/funct table match for the MIPS subset decoder.
// Depends on mipsdec_pkg for the table function and the match_t type.
module mipsdec_match import mipsdec_pkg::*; (
  input  logic [31:0] instr_word,
  output match_t      row
);

  assign row = lookup_row(instr_word[31:26], instr_word[5:0]);

endmodule

// ===== rtl/core/mipsdec_operands.sv =====
// Immediate operand selection for the MIPS subset decoder.
// Depends on mipsdec_pkg for the class codes and the match_t type.
module mipsdec_operands import mipsdec_pkg::*; (
  input  logic [31:0] instr_word,
  input  match_t      row,
  output logic [25:0] first_operand,
  output logic [31:0] second_operand,
  output logic [15:0] branch_offset
);

  logic [15:0] imm;

  assign imm = instr_word[15:0];

  always_comb begin
    first_operand  = '0;
    second_operand = '0;
    branch_offset  = '0;
    if (row.hit) begin
      case (row.cls)
        CL_R_SHAMT: first_operand = {21'd0, instr_word[10:6]};
        CL_I_ARITH: begin
          // Only addi sign-extends; addiu takes the raw immediate.
          if (row.index == IDX_ADDI) second_operand = {{16{imm[15]}}, imm};
          else                       second_operand = {16'd0, imm};
        end
        CL_I_BRANCH: branch_offset = imm;
        CL_I_LOAD: begin
          first_operand  = {10'd0, imm};
          second_operand = LUI_SHIFT;
        end
        CL_I_LOGIC, CL_I_MEM: second_operand = {16'd0, imm};
        CL_J_JUMP: first_operand = instr_word[25:0];
        default: begin
          first_operand  = '0;
          second_operand = '0;
          branch_offset  = '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mips_subset_instruction_decoder.sv =====
// MIPS subset instruction decoder, top level.
// Depends on mipsdec_pkg, mipsdec_match and mipsdec_operands.
//
// The decoder takes one instruction word and its PC per transfer on the instr channel and
// returns one decoded item per transfer on the dec channel, in order. It sustains one
// transfer per cycle in steady state while the dec channel does not stall. An accepted
// instruction passes from the input register through the table match and operand
// selection into the result register, which presents it on the dec channel. While a
// finished result waits on a stalled dec channel, the input register still takes one
// more item, so up to two items are held inside. A word that matches none of the 27
// table entries comes out with known low and all table-derived fields zero; the
// register number fields and next_pc are always filled in.
module mips_subset_instruction_decoder import mipsdec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  instr_item_t instr,
  output logic        dec_valid,
  input  logic        dec_stall,
  output dec_item_t   dec
);

  // Input register stage.
  logic        s1_valid;
  instr_item_t s1;
  logic        s1_go;

  // Decode logic between the two registers.
  match_t      row;
  logic [25:0] first_operand;
  logic [31:0] second_operand;
  logic [15:0] branch_offset;
  dec_item_t   dec_next;

  // The result register can take a new item when it is empty or its item leaves this cycle.
  assign s1_go       = !dec_valid || !dec_stall;
  assign instr_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!instr_stall) begin
      s1_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_valid && !instr_stall) begin
      s1 <= instr;
    end
  end

  mipsdec_match u_match (
    .instr_word (s1.instr_word),
    .row        (row)
  );

  mipsdec_operands u_operands (
    .instr_word     (s1.instr_word),
    .row            (row),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .branch_offset  (branch_offset)
  );

  // An unmatched row is all zeros, so the table fields need no further masking.
  always_comb begin
    dec_next.known          = row.hit;
    dec_next.entry_index    = row.index;
    dec_next.format_kind    = row.fmt;
    dec_next.operand_class  = row.cls;
    dec_next.rs_num         = s1.instr_word[25:21];
    dec_next.rt_num         = s1.instr_word[20:16];
    dec_next.rd_num         = s1.instr_word[15:11];
    dec_next.first_operand  = first_operand;
    dec_next.second_operand = second_operand;
    dec_next.branch_offset  = branch_offset;
    dec_next.access_props   = row.props;
    dec_next.next_pc        = s1.pc + PC_STEP;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (s1_go) begin
      dec_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      dec <= dec_next;
    end
  end

  // The input side only stalls while an item is parked in the input register.
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    instr_stall |-> s1_valid)
    else $error("instr_stall raised with an empty input register");

  // An item that moves out of the input register is presented on the next cycle.
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go) |=> dec_valid)
    else $error("advanced item not presented on dec");

  // The presented next_pc belongs to the item that moved forward.
  a_next_pc: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go) |=> (dec.next_pc == $past(s1.pc) + PC_STEP))
    else $error("next_pc does not follow the advanced item's pc");

endmodule

// ===== tb/sv/tb_mips_subset_instruction_decoder.sv =====
// Self-checking testbench for the MIPS subset instruction decoder.
// Needs mipsdec_pkg and mips_subset_instruction_decoder; a scoreboard class predicts each decode.
`timescale 1ns / 100ps

module tb_mips_subset_instruction_decoder;
  import mipsdec_pkg::*;

  // Directed items come first, then this many random instruction transfers.
  localparam int NUM_RANDOM     = 1870;
  // Nothing accepted on either channel for this long means the block is hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to wait after the last result, so that any extra result shows up.
  localparam int DRAIN_CYCLES   = 8;

  // The scoreboard holds its own copy of the instruction table and predicts
  // every decoded item from the instruction transfer that caused it. Results
  // come back in order, so a plain queue of predictions is enough.
  class decode_scoreboard;
    dec_item_t expected_q[$];
    int        errors;
    int        checked;
    int        unknown_words;
    int        hits[NUM_ENTRIES];

    // Returns the codes of one table row, in table order add..sw.
    function void table_row(input logic [4:0] row, output logic [5:0] opcode,
                            output logic [5:0] funct, output logic [1:0] fmt,
                            output logic [3:0] cls, output logic [7:0] props);
      opcode = OP_SPECIAL;
      funct  = '0;
      fmt    = FMT_R;
      cls    = CL_R_ARITH;
      props  = PROP_NONE;
      case (row)
        IDX_ADD:   funct = FN_ADD;
        IDX_ADDU:  funct = FN_ADDU;
        IDX_SUB:   funct = FN_SUB;
        IDX_SUBU:  funct = FN_SUBU;
        IDX_ADDI:  begin opcode = OP_ADDI;  fmt = FMT_I; cls = CL_I_ARITH; end
        IDX_ADDIU: begin opcode = OP_ADDIU; fmt = FMT_I; cls = CL_I_ARITH; end
        IDX_SLL:   begin funct = FN_SLL; cls = CL_R_SHAMT; end
        IDX_SRL:   begin funct = FN_SRL; cls = CL_R_SHAMT; end
        IDX_BEQ:   begin opcode = OP_BEQ; fmt = FMT_I; cls = CL_I_BRANCH; props = PROP_FLOW; end
        IDX_BNE:   begin opcode = OP_BNE; fmt = FMT_I; cls = CL_I_BRANCH; props = PROP_FLOW; end
        IDX_J:     begin opcode = OP_J; fmt = FMT_J; cls = CL_J_JUMP; props = PROP_FLOW; end
        IDX_JR:    begin funct = FN_JR; cls = CL_R_JUMP; props = PROP_FLOW; end
        IDX_LUI:   begin opcode = OP_LUI; fmt = FMT_I; cls = CL_I_LOAD; end
        IDX_AND:   begin funct = FN_AND; cls = CL_R_LOGIC; end
        IDX_OR:    begin funct = FN_OR;  cls = CL_R_LOGIC; end
        IDX_XOR:   begin funct = FN_XOR; cls = CL_R_LOGIC; end
        IDX_ANDI:  begin opcode = OP_ANDI; fmt = FMT_I; cls = CL_I_LOGIC; end
        IDX_ORI:   begin opcode = OP_ORI;  fmt = FMT_I; cls = CL_I_LOGIC; end
        IDX_XORI:  begin opcode = OP_XORI; fmt = FMT_I; cls = CL_I_LOGIC; end
        IDX_LB:    begin opcode = OP_LB;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_LB;  end
        IDX_LH:    begin opcode = OP_LH;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_LH;  end
        IDX_LW:    begin opcode = OP_LW;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_LW;  end
        IDX_LBU:   begin opcode = OP_LBU; fmt = FMT_I; cls = CL_I_MEM; props = PROP_LBU; end
        IDX_LHU:   begin opcode = OP_LHU; fmt = FMT_I; cls = CL_I_MEM; props = PROP_LHU; end
        IDX_SB:    begin opcode = OP_SB;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_SB;  end
        IDX_SH:    begin opcode = OP_SH;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_SH;  end
        IDX_SW:    begin opcode = OP_SW;  fmt = FMT_I; cls = CL_I_MEM; props = PROP_SW;  end
        default:   ;
      endcase
    endfunction

    // Works out the decoded item for one instruction word and PC.
    function dec_item_t decode_instr(instr_item_t item);
      dec_item_t   r;
      logic [31:0] w;
      logic [15:0] imm;
      logic [5:0]  t_op, t_fn;
      logic [1:0]  t_fmt;
      logic [3:0]  t_cls;
      logic [7:0]  t_props;
      w   = item.instr_word;
      imm = w[15:0];
      r   = '0;
      r.rs_num  = w[25:21];
      r.rt_num  = w[20:16];
      r.rd_num  = w[15:11];
      r.next_pc = item.pc + PC_STEP;
      // The first matching row wins; opcode-zero rows must match funct too.
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        table_row(5'(k), t_op, t_fn, t_fmt, t_cls, t_props);
        if (!r.known && t_op == w[31:26] && (t_op != OP_SPECIAL || t_fn == w[5:0])) begin
          r.known         = 1'b1;
          r.entry_index   = 5'(k);
          r.format_kind   = t_fmt;
          r.operand_class = t_cls;
          r.access_props  = t_props;
        end
      end
      if (r.known) begin
        case (r.operand_class)
          CL_R_SHAMT:  r.first_operand = {21'b0, w[10:6]};
          CL_I_ARITH:  r.second_operand = (r.entry_index == IDX_ADDI) ?
                                          {{16{imm[15]}}, imm} : {16'b0, imm};
          CL_I_BRANCH: r.branch_offset = imm;
          CL_I_LOAD:   begin
            r.first_operand  = {10'b0, imm};
            r.second_operand = LUI_SHIFT;
          end
          CL_I_LOGIC, CL_I_MEM: r.second_operand = {16'b0, imm};
          CL_J_JUMP:   r.first_operand = w[25:0];
          default:     ;
        endcase
      end
      return r;
    endfunction

    // Called for every accepted instruction transfer.
    function void note_instr(instr_item_t item);
      dec_item_t want;
      want = decode_instr(item);
      expected_q.push_back(want);
      if (want.known) hits[want.entry_index]++;
      else unknown_words++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Called for every accepted decoded-item transfer.
    function void check_dec(dec_item_t got);
      dec_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: decoded item with nothing pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("known",          want.known,          got.known);
      compare_field("entry_index",    want.entry_index,    got.entry_index);
      compare_field("format_kind",    want.format_kind,    got.format_kind);
      compare_field("operand_class",  want.operand_class,  got.operand_class);
      compare_field("rs_num",         want.rs_num,         got.rs_num);
      compare_field("rt_num",         want.rt_num,         got.rt_num);
      compare_field("rd_num",         want.rd_num,         got.rd_num);
      compare_field("first_operand",  want.first_operand,  got.first_operand);
      compare_field("second_operand", want.second_operand, got.second_operand);
      compare_field("branch_offset",  want.branch_offset,  got.branch_offset);
      compare_field("access_props",   want.access_props,   got.access_props);
      compare_field("next_pc",        want.next_pc,        got.next_pc);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        instr_valid;
  logic        instr_stall;
  instr_item_t instr;
  logic        dec_valid;
  logic        dec_stall;
  dec_item_t   dec;

  decode_scoreboard board;
  int idle_cycles = 0;
  int send_quiet  = 0;
  int recv_quiet  = 0;

  mips_subset_instruction_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_stall (instr_stall),
    .instr       (instr),
    .dec_valid   (dec_valid),
    .dec_stall   (dec_stall),
    .dec         (dec)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draws how many cycles a side waits before its next transfer. Now and then
  // a side goes quiet for a stretch of transfers so that back-to-back traffic
  // at the full rate is covered as well as the ragged kind.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Presents one instruction and holds it until the decoder takes it. Valid is
  // only lowered when a gap is drawn, so a back-to-back transfer never sees
  // valid dropped and raised within one time step.
  task automatic send_instr(input instr_item_t item);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr       <= item;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    board.note_instr(item);
  endtask

  // Result side: stalls for a random number of cycles, then takes the next
  // decoded item. Values are read right after the edge, before any update of
  // that edge lands, so the checker sees what the decoder presented.
  initial begin : result_side
    int hold;
    dec_stall <= 1'b0;
    @(negedge rst);
    forever begin
      hold = draw_wait(recv_quiet);
      if (hold > 0) begin
        dec_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      dec_stall <= 1'b0;
      @(posedge clk);
      while (!dec_valid) @(posedge clk);
      board.check_dec(dec);
    end
  end

  // A hung handshake on either side ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (instr_valid && !instr_stall) || (dec_valid && !dec_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, board.expected_q.size());
        $display("tb_mips_subset_instruction_decoder: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    instr_item_t item;
    logic [31:0] w;
    logic [4:0]  row;
    logic [5:0]  op, fn;
    logic [1:0]  fmt;
    logic [3:0]  cls;
    logic [7:0]  props;
    int          pick;
    int          seen;
    board = new();
    rst         <= 1'b1;
    instr_valid <= 1'b0;
    instr       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Every table entry once, with the unused bits alternating
    // between all ones and all zeros: that gives the shift amount and rs of
    // sll at 31, a negative addi immediate, and the extremes of every field.
    // The first two also take the PC across the 2^32 wrap.
    for (row = IDX_ADD; row <= IDX_SW; row++) begin
      board.table_row(row, op, fn, fmt, cls, props);
      w = row[0] ? 32'h0000_0000 : 32'hffff_ffff;
      w[31:26] = op;
      if (op == OP_SPECIAL) w[5:0] = fn;
      item.instr_word = w;
      item.pc = (row == IDX_ADD) ? 32'hffff_fffc :
                (row == IDX_ADDU) ? 32'hffff_ffff : $urandom();
      send_instr(item);
    end
    // Largest positive addi immediate, so sign extension is seen both ways.
    item.instr_word = {OP_ADDI, 10'h155, 16'h7fff};
    item.pc         = 32'h0000_0000;
    send_instr(item);
    // An opcode outside the table, with every other bit set as well.
    item.instr_word = 32'hffff_ffff;
    item.pc         = 32'hffff_fffd;
    send_instr(item);
    // Opcode zero with a funct that matches no entry.
    item.instr_word = {OP_SPECIAL, 20'hfffff, 6'h3f};
    item.pc         = $urandom();
    send_instr(item);

    // Random part. Most words are table instructions with random register
    // and immediate bits; the rest are opcode-zero words with a random funct
    // or fully random words, which are mostly unknown.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      w    = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        case ($urandom_range(0, 7))
          0:       w[15:0] = 16'h8000;
          1:       w[15:0] = 16'h7fff;
          2:       w[15:0] = 16'hffff;
          3:       w[15:0] = 16'h0000;
          default: ;
        endcase
        row = 5'($urandom_range(0, NUM_ENTRIES - 1));
        board.table_row(row, op, fn, fmt, cls, props);
        w[31:26] = op;
        if (op == OP_SPECIAL) w[5:0] = fn;
      end else if (pick < 87) begin
        w[31:26] = OP_SPECIAL;
      end
      item.instr_word = w;
      item.pc = ($urandom_range(0, 19) == 0) ? 32'hffff_ffff - $urandom_range(0, 7)
                                              : $urandom();
      send_instr(item);
    end
    instr_valid <= 1'b0;

    // Let every decoded item come back, then give the block a few more
    // cycles to show any result it should not produce.
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    seen = 0;
    foreach (board.hits[i]) if (board.hits[i] != 0) seen++;
    $display("Checked %0d decoded items: %0d unknown words, %0d of %0d table entries hit.",
             board.checked, board.unknown_words, seen, NUM_ENTRIES);
    $display("Both channels ran with random gaps of 0 to 13 cycles and gap-free stretches.");
    if (board.errors == 0) begin
      $display("tb_mips_subset_instruction_decoder: PASS");
    end else begin
      $display("%0d mismatches found.", board.errors);
      $display("tb_mips_subset_instruction_decoder: FAIL");
    end
    $finish;
  end

endmodule
